/* design/fcc_pkg.sv */
// Shared types, constants and helper functions of the palette chunk decoder.
package fcc_pkg;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_CNT_HI = 3'd1,
    PH_SKIP   = 3'd2,
    PH_COPY   = 3'd3,
    PH_RED    = 3'd4,
    PH_GREEN  = 3'd5,
    PH_BLUE   = 3'd6,
    PH_DONE   = 3'd7
  } fcc_phase_t;

  localparam logic [9:0] INDEX_MAX = 10'd1023;
  localparam logic [8:0] COPY_FULL = 9'd256;

  // Raw palette write as the parser leaves it; the back end widens the colors.
  typedef struct packed {
    logic [7:0] index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } fcc_entry_t;

  // Six-to-eight bit widening, kept to eight bits for out-of-range inputs.
  function automatic logic [7:0] widen6(input logic [7:0] v);
    widen6 = {v[5:0], 2'b00} | {4'b0000, v[7:4]};
  endfunction

  // Index add that saturates at the top of the ten-bit range.
  function automatic logic [9:0] index_add(input logic [9:0] a, input logic [7:0] b);
    logic [10:0] s;
    s = {1'b0, a} + {3'b000, b};
    index_add = (s > {1'b0, INDEX_MAX}) ? INDEX_MAX : s[9:0];
  endfunction

endpackage

/* design/fcc_channels.sv */
// Valid/ready channel interfaces for chunk bytes and palette writes.
interface fcc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       chunk_start;

  modport source (output valid, output data_byte, output chunk_start, input ready);
  modport sink   (input valid, input data_byte, input chunk_start, output ready);
endinterface

interface fcc_palette_if;
  logic       valid;
  logic       ready;
  logic [7:0] entry_index;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       last_entry;

  modport source (output valid, output entry_index, output red, output green,
                  output blue, output last_entry, input ready);
  modport sink   (input valid, input entry_index, input red, input green,
                  input blue, input last_entry, output ready);
endinterface

/* design/fcc_parser.sv */
// Front end: accepts chunk bytes, tracks the parse phase and issues palette writes.
module fcc_parser (
  input  logic               clk,
  input  logic               rst,
  fcc_byte_if.sink           byte_in,
  input  logic               queue_full,
  output logic               push,
  output fcc_pkg::fcc_entry_t push_entry
);
  import fcc_pkg::*;

  fcc_phase_t phase, phase_next;
  logic [7:0]  count_low, count_low_next;
  logic [15:0] packets_left, packets_left_next;
  logic [8:0]  entries_left, entries_left_next;
  logic [9:0]  next_index, next_index_next;
  logic [7:0]  red_hold, red_hold_next;
  logic [7:0]  green_hold, green_hold_next;

  logic        fire;
  logic [15:0] packet_count;
  logic [8:0]  entries_dec;
  logic [15:0] packets_dec;

  assign byte_in.ready = !queue_full;
  assign fire          = byte_in.valid && byte_in.ready;
  assign packet_count  = {byte_in.data_byte, count_low};
  assign entries_dec   = (entries_left != 9'd0) ? entries_left - 9'd1 : 9'd0;
  assign packets_dec   = (packets_left != 16'd0) ? packets_left - 16'd1 : 16'd0;

  always_comb begin
    phase_next = phase;
    if (fire) begin
      if (byte_in.chunk_start) begin
        phase_next = PH_CNT_HI;
      end else begin
        case (phase)
          PH_CNT_HI: phase_next = (packet_count == 16'd0) ? PH_DONE : PH_SKIP;
          PH_SKIP:   phase_next = PH_COPY;
          PH_COPY:   phase_next = PH_RED;
          PH_RED:    phase_next = PH_GREEN;
          PH_GREEN:  phase_next = PH_BLUE;
          PH_BLUE: begin
            if (entries_dec == 9'd0) begin
              phase_next = (packets_dec == 16'd0) ? PH_DONE : PH_SKIP;
            end else begin
              phase_next = PH_RED;
            end
          end
          default:   phase_next = phase;
        endcase
      end
    end
  end

  always_comb begin
    count_low_next    = count_low;
    packets_left_next = packets_left;
    entries_left_next = entries_left;
    next_index_next   = next_index;
    red_hold_next     = red_hold;
    green_hold_next   = green_hold;
    push              = 1'b0;
    push_entry.index  = next_index[7:0];
    push_entry.red    = red_hold;
    push_entry.green  = green_hold;
    push_entry.blue   = byte_in.data_byte;
    push_entry.last   = (entries_left == 9'd1) && (packets_left == 16'd1);
    if (fire) begin
      if (byte_in.chunk_start) begin
        count_low_next    = byte_in.data_byte;
        packets_left_next = 16'd0;
        entries_left_next = 9'd0;
        next_index_next   = 10'd0;
        red_hold_next     = 8'd0;
        green_hold_next   = 8'd0;
      end else begin
        case (phase)
          PH_CNT_HI: packets_left_next = packet_count;
          PH_SKIP:   next_index_next = index_add(next_index, byte_in.data_byte);
          PH_COPY: begin
            entries_left_next = (byte_in.data_byte == 8'd0) ? COPY_FULL
                                                            : {1'b0, byte_in.data_byte};
          end
          PH_RED:    red_hold_next = byte_in.data_byte;
          PH_GREEN:  green_hold_next = byte_in.data_byte;
          PH_BLUE: begin
            // Writes past entry 255 are consumed but never issued.
            push              = (next_index[9:8] == 2'b00);
            next_index_next   = index_add(next_index, 8'd1);
            entries_left_next = entries_dec;
            if (entries_dec == 9'd0) begin
              packets_left_next = packets_dec;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      count_low    <= 8'd0;
      packets_left <= 16'd0;
      entries_left <= 9'd0;
      next_index   <= 10'd0;
      red_hold     <= 8'd0;
      green_hold   <= 8'd0;
    end else begin
      phase        <= phase_next;
      count_low    <= count_low_next;
      packets_left <= packets_left_next;
      entries_left <= entries_left_next;
      next_index   <= next_index_next;
      red_hold     <= red_hold_next;
      green_hold   <= green_hold_next;
    end
  end

endmodule

/* design/fcc_queue.sv */
// Short register queue of raw palette writes between parser and output stage.
module fcc_queue #(
  parameter int Depth = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  fcc_pkg::fcc_entry_t push_entry,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output fcc_pkg::fcc_entry_t head_entry
);
  import fcc_pkg::*;

  localparam int PtrWidth   = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CountWidth = $clog2(Depth + 1);
  localparam logic [PtrWidth-1:0]   LastSlot  = PtrWidth'(Depth - 1);
  localparam logic [CountWidth-1:0] FullCount = CountWidth'(Depth);

  fcc_entry_t slots [Depth];
  logic [PtrWidth-1:0]   wr_ptr, rd_ptr;
  logic [CountWidth-1:0] count;
  logic                  do_push, do_pop;

  assign full       = (count == FullCount);
  assign head_valid = (count != '0);
  assign head_entry = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LastSlot) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastSlot) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* design/fcc_widen.sv */
// Back end: widens queued colors and holds the palette write in the output register.
module fcc_widen (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  fcc_pkg::fcc_entry_t head_entry,
  output logic                pop,
  fcc_palette_if.source       pal_out
);
  import fcc_pkg::*;

  logic       out_valid;
  logic [7:0] out_index, out_red, out_green, out_blue;
  logic       out_last;

  // The register reloads whenever it is empty or its request is being taken.
  assign pop = head_valid && (!out_valid || pal_out.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || pal_out.ready) begin
      out_valid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_index <= head_entry.index;
      out_red   <= widen6(head_entry.red);
      out_green <= widen6(head_entry.green);
      out_blue  <= widen6(head_entry.blue);
      out_last  <= head_entry.last;
    end
  end

  assign pal_out.valid       = out_valid;
  assign pal_out.entry_index = out_index;
  assign pal_out.red         = out_red;
  assign pal_out.green       = out_green;
  assign pal_out.blue        = out_blue;
  assign pal_out.last_entry  = out_last;

endmodule

/* design/fli_color_chunk_decoder.sv */
// Top level: byte-serial 6-bit palette chunk decoder.
// Takes one chunk byte per cycle; the parser updates its phase in the cycle a byte is taken.
// A palette write enters the write queue as its blue byte is taken, then the output register, held until accepted.
// Throughput is one byte per cycle; the input stalls only when the write queue is full.
// Synchronous reset returns the parser to idle and empties the queue and output register.
module fli_color_chunk_decoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  fcc_byte_if.sink      byte_in,
  fcc_palette_if.source pal_out
);
  import fcc_pkg::*;

  fcc_entry_t push_entry, head_entry;
  logic       push, queue_full, pop, head_valid;

  fcc_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .byte_in    (byte_in),
    .queue_full (queue_full),
    .push       (push),
    .push_entry (push_entry)
  );

  fcc_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  fcc_widen u_widen (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop),
    .pal_out    (pal_out)
  );

endmodule
